@@ src/sfd_pkg.sv @@
// shared types, constants and the crc-16 byte update for the stuffed frame decoder
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

    // crc-16 (poly 0x1021, init 0, msb first, no final xor)
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [7:0]  ESC_FLIP = 8'h20;

    // header bytes before the payload: sync and two length bytes
    localparam logic [16:0] HEADER_BYTES = 17'd3;

    // register reset values
    localparam logic [7:0]  SYNC_RESET    = 8'h7E;
    localparam logic [7:0]  ESCAPE_RESET  = 8'h7D;
    localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

    // register indexes on the apb port (byte address bits [3:2])
    typedef enum logic [1:0] {
        REG_SYNC    = 2'd0,
        REG_ESCAPE  = 2'd1,
        REG_MAX_LEN = 2'd2
    } t_reg_idx;

    // result kinds
    typedef enum logic [2:0] {
        KIND_PAYLOAD = 3'd0,
        KIND_GOOD    = 3'd1,
        KIND_CRC_BAD = 3'd2,
        KIND_ABORT   = 3'd3,
        KIND_OVERLEN = 3'd4
    } t_kind;

    // configuration handed from the register block to the deframer
    typedef struct packed {
        logic [7:0]  sync_byte;
        logic [7:0]  escape_byte;
        logic [15:0] len_limit;
    } t_cfg;

    // one result item
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [15:0] frame_length;
        logic        last;
        logic [15:0] crc_error_total;
    } t_result;

    // one byte through the crc, eight shift steps
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ src/sfd_apb_regs.sv @@
// apb configuration registers: sync byte, escape byte, max length
// depends on sfd_pkg for register indexes, reset values and t_cfg
`timescale 1ns / 1ps
`default_nettype none

module sfd_apb_regs
    import sfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    logic [7:0]  r_sync;
    logic [7:0]  r_escape;
    logic [15:0] r_max_len;
    t_reg_idx    w_idx;
    logic        w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    // register writes on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync    <= SYNC_RESET;
            r_escape  <= ESCAPE_RESET;
            r_max_len <= MAX_LEN_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_SYNC:    r_sync    <= pwdata[7:0];
                REG_ESCAPE:  r_escape  <= pwdata[7:0];
                REG_MAX_LEN: r_max_len <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            REG_SYNC:    prdata = {24'd0, r_sync};
            REG_ESCAPE:  prdata = {24'd0, r_escape};
            REG_MAX_LEN: prdata = {16'd0, r_max_len};
            default:     prdata = 32'd0;
        endcase
    end

    assign o_cfg = '{sync_byte: r_sync, escape_byte: r_escape, len_limit: r_max_len};

endmodule

`default_nettype wire

@@ src/sfd_deframer.sv @@
// frame state and the per-byte step: unescape, header, crc, status
// depends on sfd_pkg for t_cfg, t_result, kinds and crc16_byte
`timescale 1ns / 1ps
`default_nettype none

module sfd_deframer
    import sfd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    output logic            o_res_valid,
    output t_result         o_res
);

    logic [16:0] r_position, n_position;
    logic [15:0] r_len,      n_len;
    logic [15:0] r_crc,      n_crc;
    logic        r_esc_pend, n_esc_pend;
    logic [7:0]  r_crc_hi,   n_crc_hi;
    logic [15:0] r_fail_cnt, n_fail_cnt;
    logic        r_dropping, n_dropping;

    logic        w_in_frame;
    logic [7:0]  w_b;
    logic [16:0] w_idx;

    assign w_in_frame = (r_position != 17'd0);
    assign w_b        = r_esc_pend ? (i_byte ^ ESC_FLIP) : i_byte;
    assign w_idx      = r_position - HEADER_BYTES;

    // next state and result for one byte
    always_comb begin
        n_position  = r_position;
        n_len       = r_len;
        n_crc       = r_crc;
        n_esc_pend  = r_esc_pend;
        n_crc_hi    = r_crc_hi;
        n_fail_cnt  = r_fail_cnt;
        n_dropping  = r_dropping;
        o_res_valid = 1'b0;
        o_res.kind         = KIND_PAYLOAD;
        o_res.data_byte    = 8'd0;
        o_res.byte_index   = 16'd0;
        o_res.frame_length = r_len;
        o_res.last         = 1'b1;

        if (w_in_frame && i_byte == i_cfg.sync_byte) begin
            // sync inside a frame aborts it and restarts
            o_res_valid = !r_dropping;
            o_res.kind  = KIND_ABORT;
            n_dropping  = 1'b0;
            n_position  = 17'd1;
            n_len       = 16'd0;
            n_crc       = 16'd0;
            n_esc_pend  = 1'b0;
        end else if (r_dropping) begin
            // discard until next sync
        end else if (w_in_frame && i_byte == i_cfg.escape_byte) begin
            n_esc_pend = 1'b1;
        end else begin
            n_esc_pend = 1'b0;
            if (r_position == 17'd0) begin
                // hunting
                if (w_b == i_cfg.sync_byte) begin
                    n_position = 17'd1;
                    n_crc      = 16'd0;
                end
            end else if (r_position == 17'd1) begin
                n_len      = {w_b, 8'h00};
                n_position = 17'd2;
            end else if (r_position == 17'd2) begin
                n_len      = r_len | {8'h00, w_b};
                n_position = 17'd3;
            end else if (r_position > {1'b0, i_cfg.len_limit}) begin
                // overlength: report and drop the rest
                o_res_valid = 1'b1;
                o_res.kind  = KIND_OVERLEN;
                n_dropping  = 1'b1;
            end else begin
                n_position = r_position + 17'd1;
                if (w_idx < {1'b0, r_len}) begin
                    // payload byte
                    n_crc            = crc16_byte(r_crc, w_b);
                    o_res_valid      = 1'b1;
                    o_res.kind       = KIND_PAYLOAD;
                    o_res.data_byte  = w_b;
                    o_res.byte_index = w_idx[15:0];
                    o_res.last       = 1'b0;
                end else if (w_idx == {1'b0, r_len}) begin
                    n_crc_hi = w_b;
                end else begin
                    // low crc byte closes the frame
                    n_position  = 17'd0;
                    n_len       = 16'd0;
                    o_res_valid = 1'b1;
                    if ({r_crc_hi, w_b} == r_crc) begin
                        o_res.kind = KIND_GOOD;
                    end else begin
                        o_res.kind = KIND_CRC_BAD;
                        n_fail_cnt = r_fail_cnt + 16'd1;
                    end
                end
            end
        end
        o_res.crc_error_total = n_fail_cnt;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= 17'd0;
            r_len      <= 16'd0;
            r_crc      <= 16'd0;
            r_esc_pend <= 1'b0;
            r_crc_hi   <= 8'd0;
            r_fail_cnt <= 16'd0;
            r_dropping <= 1'b0;
        end else if (i_step) begin
            r_position <= n_position;
            r_len      <= n_len;
            r_crc      <= n_crc;
            r_esc_pend <= n_esc_pend;
            r_crc_hi   <= n_crc_hi;
            r_fail_cnt <= n_fail_cnt;
            r_dropping <= n_dropping;
        end
    end

`ifndef SYNTHESIS
    // dropping only happens past the header
    a_drop_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dropping |-> (r_position >= HEADER_BYTES))
        else $error("dropping outside payload area");

    // an escape can only be pending inside a frame
    a_esc_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc_pend |-> w_in_frame)
        else $error("escape pending while hunting");

    // fail count moves by one on each crc bad status
    a_fail_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res_valid && o_res.kind == KIND_CRC_BAD)
        |=> (r_fail_cnt == 16'($past(r_fail_cnt) + 16'd1)))
        else $error("crc fail count not incremented");
`endif

endmodule

`default_nettype wire

@@ src/stuffed_frame_decoder_crc16_core.sv @@
// path: an accepted byte waits in the input register, then steps through the deframer into the result register
// throughput: one byte per cycle while the output side keeps taking results
// a stalled result holds the next byte in the input register; input stalls once both are full
// reset: synchronous active-low i_rst_n; clears registers to defaults and state to hunting
// depends on sfd_pkg, sfd_apb_regs, sfd_deframer
`timescale 1ns / 1ps
`default_nettype none

module stuffed_frame_decoder_crc16_core
    import sfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    // output stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [55:0]      o_m_axis_tdata,   // [7:0] data_byte, [23:8] byte_index,
                                               // [39:24] frame_length, [55:40] crc_error_total
    output logic [2:0]       o_m_axis_tuser,   // [2:0] kind
    output logic             o_m_axis_tlast,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_cfg       w_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       w_step;
    logic       w_res_valid;
    t_result    w_res;
    logic       r_out_valid;
    t_result    r_out;

    sfd_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // byte moves into the deframer when the result slot is free or draining
    assign w_step          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_step;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    sfd_deframer u_deframer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_step      (w_step),
        .i_byte      (r_in_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= w_res_valid;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.crc_error_total, r_out.frame_length,
                              r_out.byte_index, r_out.data_byte};
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out.last;

`ifndef SYNTHESIS
    // last marks exactly the status results
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (r_out.kind != KIND_PAYLOAD)))
        else $error("tlast does not match result kind");
`endif

endmodule

`default_nettype wire
